/* rtl/core/bss_pkg.sv */
`default_nettype none
package bss_pkg;

	// divider geometry
	localparam int DVD_W     = 32;
	localparam int DVS_W     = 16;
	localparam int QUO_W     = 16;
	localparam int DIV_STEPS = DVD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_OC_LIMIT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCK_MIN_RPM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OL_TIMEOUT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCK_EVENTS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIMEOUT = 3'd6;

	localparam logic [15:0] RST_OC_LIMIT      = 16'd7800;
	localparam logic [31:0] RST_PRODUCT       = 32'd10000000;
	localparam logic [15:0] RST_LOCK_MIN_RPM  = 16'd900;
	localparam logic [7:0]  RST_ALIGN_LEN     = 8'd12;
	localparam logic [7:0]  RST_OL_TIMEOUT    = 8'd28;
	localparam logic [7:0]  RST_LOCK_EVENTS   = 8'd3;
	localparam logic [7:0]  RST_STALL_TIMEOUT = 8'd8;

	// commutation period ramp
	localparam logic [15:0] START_PERIOD_US = 16'd3200;
	localparam logic [15:0] MIN_PERIOD_US   = 16'd1100;
	localparam logic [15:0] PERIOD_STEP_US  = 16'd100;

	// duty limits in percent
	localparam logic [6:0] ALIGN_DUTY_LO  = 7'd18;
	localparam logic [6:0] ALIGN_DUTY_HI  = 7'd28;
	localparam logic [6:0] OPEN_DUTY_LO   = 7'd20;
	localparam logic [6:0] OPEN_DUTY_HI   = 7'd55;
	localparam logic [6:0] OPEN_DUTY_OFS  = 7'd8;
	localparam logic [6:0] LOCK_DUTY_LO   = 7'd24;
	localparam logic [6:0] LOCK_DUTY_HI   = 7'd70;
	localparam logic [6:0] CLOSED_DUTY_LO = 7'd24;
	localparam logic [6:0] CLOSED_DUTY_HI = 7'd80;

	localparam logic [2:0] LAST_SECTOR = 3'd5;

	localparam logic [2:0] FAULT_OVERCURRENT = 3'b001;
	localparam logic [2:0] FAULT_NO_LOCK     = 3'b010;
	localparam logic [2:0] FAULT_STALL       = 3'b100;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_ALIGN  = 3'd1,
		MODE_OPEN   = 3'd2,
		MODE_CLOSED = 3'd3,
		MODE_FAULT  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		LOCK_NONE    = 2'd0,
		LOCK_SEEKING = 2'd1,
		LOCK_LOCKED  = 2'd2,
		LOCK_LOST    = 2'd3
	} lock_t;

	// what to do with the quotient once the divider finishes
	typedef enum logic [1:0] {
		POST_NONE,
		POST_SPEED,
		POST_PERIOD,
		POST_OPEN_SPEED
	} post_op_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_PRE,
		CS_DIV,
		CS_DONE
	} ctl_state_t;

	typedef struct packed {
		logic [15:0] oc_limit;
		logic [31:0] product;
		logic [15:0] lock_min_rpm;
		logic [7:0]  align_len;
		logic [7:0]  ol_timeout;
		logic [7:0]  lock_events;
		logic [7:0]  stall_timeout;
	} cfg_t;

	typedef struct packed {
		logic        start_request;
		logic        clear_request;
		logic [6:0]  throttle;
		logic [15:0] phase_current;
		logic        zero_crossing;
		logic [15:0] measured_speed;
	} in_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [2:0]  sector;
		logic [1:0]  lock_status;
		logic [6:0]  duty;
		logic [15:0] period_us;
		logic [15:0] speed_estimate;
		logic [2:0]  fault_mask;
	} res_t;

	typedef struct packed {
		mode_t       mode;
		logic [2:0]  sector;
		lock_t       lock;
		logic [6:0]  duty;
		logic [15:0] period;
		logic [15:0] speed;
		logic [2:0]  fault;
		logic [7:0]  align_cnt;
		logic [7:0]  ramp_cnt;
		logic [7:0]  cross_cnt;
		logic [7:0]  miss_cnt;
	} arch_t;

	localparam arch_t ARCH_CLEAR = '{
		mode:      MODE_IDLE,
		sector:    3'd0,
		lock:      LOCK_NONE,
		duty:      7'd0,
		period:    16'd0,
		speed:     16'd0,
		fault:     3'd0,
		align_cnt: 8'd0,
		ramp_cnt:  8'd0,
		cross_cnt: 8'd0,
		miss_cnt:  8'd0
	};

	function automatic logic [6:0] bound7(input logic [6:0] v, input logic [6:0] lo,
			input logic [6:0] hi);
		logic [6:0] r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	function automatic logic [7:0] sat_inc8(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic logic [2:0] next_sector(input logic [2:0] s);
		return (s >= LAST_SECTOR) ? 3'd0 : s + 3'd1;
	endfunction

	function automatic logic [6:0] open_duty(input logic [6:0] thr);
		logic [6:0] d;
		d = (thr >= OPEN_DUTY_OFS) ? thr - OPEN_DUTY_OFS : 7'd0;
		return bound7(d, OPEN_DUTY_LO, OPEN_DUTY_HI);
	endfunction

	function automatic arch_t go_fault(input arch_t a, input logic [2:0] fbit);
		arch_t r;
		r = a;
		r.mode   = MODE_FAULT;
		r.lock   = LOCK_LOST;
		r.fault  = a.fault | fbit;
		r.duty   = 7'd0;
		r.period = 16'd0;
		r.speed  = 16'd0;
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/bss_div.sv */
`default_nettype none
module bss_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [bss_pkg::DVD_W-1:0] dividend,
	input  wire logic [bss_pkg::DVS_W-1:0] divisor,
	output logic                           done,
	output logic [bss_pkg::QUO_W-1:0]      quotient
);
	import bss_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 ovf_q;

	logic [DVS_W:0]   rem_ext;
	logic [DVS_W:0]   diff;
	logic             ge;

	// restoring division, one quotient bit per cycle, msb first
	assign rem_ext = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = (rem_ext >= {1'b0, dvs_q});
	assign diff    = rem_ext - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[DVS_W-1:0] : rem_ext[DVS_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
			// any bit pushed out of the narrow quotient means saturation
			ovf_q <= ovf_q | quo_q[QUO_W-1];
		end
	end

	assign done     = done_q;
	assign quotient = ovf_q ? '1 : quo_q;

endmodule
`default_nettype wire

/* rtl/core/bss_ctrl.sv */
`default_nettype none
module bss_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire bss_pkg::cfg_t             cfg,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire bss_pkg::in_t              in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output bss_pkg::res_t                  out_data,
	output logic                           div_start,
	output logic [bss_pkg::DVS_W-1:0]      div_divisor,
	input  wire logic                      div_done,
	input  wire logic [bss_pkg::QUO_W-1:0] div_quotient
);
	import bss_pkg::*;

	ctl_state_t state_q, state_d;
	arch_t      arch_q, arch_d;
	post_op_t   op_q, op_d;
	in_t        in_q;
	res_t       out_q;
	logic       out_valid_q;
	logic       out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			arch_q  <= ARCH_CLEAR;
			op_q    <= POST_NONE;
		end else begin
			state_q <= state_d;
			arch_q  <= arch_d;
			op_q    <= op_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
		end
	end

	always_comb begin
		arch_t       a;
		post_op_t    op;
		logic [15:0] dvs;
		logic [6:0]  thr;
		a           = arch_q;
		op          = POST_NONE;
		dvs         = '0;
		thr         = in_q.throttle;
		state_d     = state_q;
		arch_d      = arch_q;
		op_d        = op_q;
		in_ready    = 1'b0;
		div_start   = 1'b0;
		div_divisor = '0;
		out_load    = 1'b0;
		case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = CS_PRE;
				end
			end
			CS_PRE: begin
				if (in_q.clear_request) begin
					a = ARCH_CLEAR;
				end
				if (in_q.start_request && a.mode == MODE_IDLE) begin
					a       = ARCH_CLEAR;
					a.mode  = MODE_ALIGN;
					a.lock  = LOCK_SEEKING;
					a.duty  = bound7(thr >> 1, ALIGN_DUTY_LO, ALIGN_DUTY_HI);
				end
				if ((a.mode == MODE_ALIGN || a.mode == MODE_OPEN || a.mode == MODE_CLOSED)
						&& in_q.phase_current >= cfg.oc_limit) begin
					a = go_fault(a, FAULT_OVERCURRENT);
				end else begin
					case (a.mode)
						MODE_ALIGN: begin
							a.align_cnt = sat_inc8(a.align_cnt);
							a.duty      = bound7(thr >> 1, ALIGN_DUTY_LO, ALIGN_DUTY_HI);
							a.speed     = '0;
							if (a.align_cnt >= cfg.align_len) begin
								a.mode      = MODE_OPEN;
								a.period    = START_PERIOD_US;
								a.duty      = open_duty(thr);
								a.ramp_cnt  = '0;
								a.cross_cnt = '0;
							end
						end
						MODE_OPEN: begin
							a.ramp_cnt = sat_inc8(a.ramp_cnt);
							a.sector   = next_sector(a.sector);
							if (a.period > MIN_PERIOD_US) begin
								a.period = (a.period >= MIN_PERIOD_US + PERIOD_STEP_US)
									? a.period - PERIOD_STEP_US : MIN_PERIOD_US;
							end
							a.duty = open_duty(thr);
							if (in_q.zero_crossing) begin
								a.cross_cnt = sat_inc8(a.cross_cnt);
							end
							if (in_q.measured_speed != '0) begin
								a.speed = in_q.measured_speed;
								if (a.cross_cnt >= cfg.lock_events
										&& in_q.measured_speed >= cfg.lock_min_rpm) begin
									a.mode     = MODE_CLOSED;
									a.lock     = LOCK_LOCKED;
									a.duty     = bound7(thr, LOCK_DUTY_LO, LOCK_DUTY_HI);
									a.miss_cnt = '0;
									op         = POST_PERIOD;
									dvs        = in_q.measured_speed;
								end else if (a.ramp_cnt > cfg.ol_timeout) begin
									a = go_fault(a, FAULT_NO_LOCK);
								end
							end else begin
								// lock decision waits for the speed estimate
								op  = POST_OPEN_SPEED;
								dvs = a.period;
							end
						end
						MODE_CLOSED: begin
							a.duty = bound7(thr, CLOSED_DUTY_LO, CLOSED_DUTY_HI);
							if (in_q.zero_crossing) begin
								a.sector   = next_sector(a.sector);
								a.miss_cnt = '0;
								if (in_q.measured_speed != '0) begin
									a.speed = in_q.measured_speed;
									op      = POST_PERIOD;
									dvs     = in_q.measured_speed;
								end else begin
									op  = POST_SPEED;
									dvs = a.period;
								end
							end else begin
								a.miss_cnt = sat_inc8(a.miss_cnt);
								if (a.miss_cnt > cfg.stall_timeout) begin
									a = go_fault(a, FAULT_STALL);
								end else begin
									op  = POST_SPEED;
									dvs = a.period;
								end
							end
						end
						default: begin
						end
					endcase
				end
				arch_d      = a;
				op_d        = op;
				div_divisor = dvs;
				if (op != POST_NONE) begin
					div_start = 1'b1;
					state_d   = CS_DIV;
				end else begin
					state_d = CS_DONE;
				end
			end
			CS_DIV: begin
				if (div_done) begin
					case (op_q)
						POST_SPEED: begin
							a.speed = div_quotient;
						end
						POST_PERIOD: begin
							a.period = div_quotient;
						end
						POST_OPEN_SPEED: begin
							a.speed = div_quotient;
							if (a.cross_cnt >= cfg.lock_events
									&& div_quotient >= cfg.lock_min_rpm) begin
								a.mode     = MODE_CLOSED;
								a.lock     = LOCK_LOCKED;
								a.duty     = bound7(thr, LOCK_DUTY_LO, LOCK_DUTY_HI);
								a.miss_cnt = '0;
							end else if (a.ramp_cnt > cfg.ol_timeout) begin
								a = go_fault(a, FAULT_NO_LOCK);
							end
						end
						default: begin
						end
					endcase
					arch_d  = a;
					state_d = CS_DONE;
				end
			end
			CS_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.mode           <= arch_q.mode;
			out_q.sector         <= arch_q.sector;
			out_q.lock_status    <= arch_q.lock;
			out_q.duty           <= arch_q.duty;
			out_q.period_us      <= arch_q.period;
			out_q.speed_estimate <= arch_q.speed;
			out_q.fault_mask     <= arch_q.fault;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

/* rtl/core/sensorless_bldc_startup_sequencer.sv */
`default_nettype none
// Start-up sequencer for a sensorless BLDC drive, one input transfer per control tick.
// A tick whose step needs no rpm/period conversion passes the pre and done states;
// a tick that converts (open-loop speed estimate, closed-loop speed or period, period
// at lock) also waits in the divide state for the shared restoring divider, which
// produces one quotient bit per cycle over the 32-bit rpm_period_product. Results
// sit in an output register, so a new tick is taken while the previous result waits for
// out_ready. Configuration writes take effect at once and belong between ticks.
module sensorless_bldc_startup_sequencer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [bss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           start_request,
	input  wire logic                           clear_request,
	input  wire logic [6:0]                     throttle,
	input  wire logic [15:0]                    phase_current,
	input  wire logic                           zero_crossing,
	input  wire logic [15:0]                    measured_speed,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [2:0]                          mode,
	output logic [2:0]                          sector,
	output logic [1:0]                          lock_status,
	output logic [6:0]                          duty,
	output logic [15:0]                         period_us,
	output logic [15:0]                         speed_estimate,
	output logic [2:0]                          fault_mask
);
	import bss_pkg::*;

	cfg_t             cfg_q;
	in_t              in_data;
	res_t             out_data;
	logic             div_start;
	logic [DVS_W-1:0] div_divisor;
	logic             div_done;
	logic [QUO_W-1:0] div_quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.oc_limit      <= RST_OC_LIMIT;
			cfg_q.product       <= RST_PRODUCT;
			cfg_q.lock_min_rpm  <= RST_LOCK_MIN_RPM;
			cfg_q.align_len     <= RST_ALIGN_LEN;
			cfg_q.ol_timeout    <= RST_OL_TIMEOUT;
			cfg_q.lock_events   <= RST_LOCK_EVENTS;
			cfg_q.stall_timeout <= RST_STALL_TIMEOUT;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_OC_LIMIT:      cfg_q.oc_limit      <= cfg_data[15:0];
				CFG_PRODUCT:       cfg_q.product       <= cfg_data[31:0];
				CFG_LOCK_MIN_RPM:  cfg_q.lock_min_rpm  <= cfg_data[15:0];
				CFG_ALIGN_LEN:     cfg_q.align_len     <= cfg_data[7:0];
				CFG_OL_TIMEOUT:    cfg_q.ol_timeout    <= cfg_data[7:0];
				CFG_LOCK_EVENTS:   cfg_q.lock_events   <= cfg_data[7:0];
				CFG_STALL_TIMEOUT: cfg_q.stall_timeout <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign in_data.start_request  = start_request;
	assign in_data.clear_request  = clear_request;
	assign in_data.throttle       = throttle;
	assign in_data.phase_current  = phase_current;
	assign in_data.zero_crossing  = zero_crossing;
	assign in_data.measured_speed = measured_speed;

	bss_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.div_start    (div_start),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quotient (div_quotient)
	);

	bss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cfg_q.product),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign mode           = out_data.mode;
	assign sector         = out_data.sector;
	assign lock_status    = out_data.lock_status;
	assign duty           = out_data.duty;
	assign period_us      = out_data.period_us;
	assign speed_estimate = out_data.speed_estimate;
	assign fault_mask     = out_data.fault_mask;

endmodule
`default_nettype wire

/* sim/sensorless_bldc_startup_sequencer_test.sv */
`timescale 1ns / 1ps

module sensorless_bldc_startup_sequencer_test;
	import bss_pkg::*;

	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int MAX_WAIT         = 8;
	localparam int DRAIN_CYCLES     = 48;
	localparam int RANDOM_PHASES    = 9;
	localparam int PHASE_TICKS      = 80;
	localparam int MISMATCH_REPORTS = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  start_request;
	logic                  clear_request;
	logic [6:0]            throttle;
	logic [15:0]           phase_current;
	logic                  zero_crossing;
	logic [15:0]           measured_speed;
	logic                  out_valid;
	logic                  out_ready;
	logic [2:0]            mode;
	logic [2:0]            sector;
	logic [1:0]            lock_status;
	logic [6:0]            duty;
	logic [15:0]           period_us;
	logic [15:0]           speed_estimate;
	logic [2:0]            fault_mask;

	// predicted sequencer state
	mode_t       pr_mode;
	logic [2:0]  pr_sector;
	lock_t       pr_lock;
	logic [6:0]  pr_duty;
	logic [15:0] pr_period;
	logic [15:0] pr_speed;
	logic [2:0]  pr_fault;
	logic [7:0]  align_progress;
	logic [7:0]  ramp_ticks;
	logic [7:0]  crossings;
	logic [7:0]  missed_ticks;

	// shadow of the configuration registers
	logic [15:0] oc_limit_ma;
	logic [31:0] rpm_product;
	logic [15:0] lock_rpm;
	logic [7:0]  align_len;
	logic [7:0]  ol_timeout;
	logic [7:0]  lock_events;
	logic [7:0]  stall_limit;

	res_t predicted_status[$];
	int   mismatches;
	bit   steady_flow;
	int   zc_percent;

	sensorless_bldc_startup_sequencer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.start_request  (start_request),
		.clear_request  (clear_request),
		.throttle       (throttle),
		.phase_current  (phase_current),
		.zero_crossing  (zero_crossing),
		.measured_speed (measured_speed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.mode           (mode),
		.sector         (sector),
		.lock_status    (lock_status),
		.duty           (duty),
		.period_us      (period_us),
		.speed_estimate (speed_estimate),
		.fault_mask     (fault_mask)
	);

	always #10 clk = ~clk;

	function automatic int draw_gap();
		if (steady_flow) begin
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic logic [6:0] clamp_pct(input int v, input logic [6:0] lo,
			input logic [6:0] hi);
		if (v < int'(lo)) begin
			return lo;
		end
		if (v > int'(hi)) begin
			return hi;
		end
		return 7'(v);
	endfunction

	// throttle minus offset, floored at zero before clamping
	function automatic logic [6:0] ramp_duty(input int thr);
		return clamp_pct((thr >= int'(OPEN_DUTY_OFS)) ? thr - int'(OPEN_DUTY_OFS) : 0,
			OPEN_DUTY_LO, OPEN_DUTY_HI);
	endfunction

	function automatic logic [7:0] count_up(input logic [7:0] c);
		return (c == 8'hFF) ? c : c + 8'd1;
	endfunction

	// product / x, saturated; a zero divisor saturates like the hardware divider
	function automatic logic [15:0] product_over(input logic [15:0] x);
		logic [31:0] q;
		if (x == 16'd0) begin
			return 16'hFFFF;
		end
		q = rpm_product / {16'd0, x};
		return (q > 32'd65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic logic [2:0] sector_after(input logic [2:0] s);
		return (s >= LAST_SECTOR) ? 3'd0 : s + 3'd1;
	endfunction

	function automatic void clear_sequencer();
		pr_mode        = MODE_IDLE;
		pr_sector      = 3'd0;
		pr_lock        = LOCK_NONE;
		pr_duty        = 7'd0;
		pr_period      = 16'd0;
		pr_speed       = 16'd0;
		pr_fault       = 3'd0;
		align_progress = 8'd0;
		ramp_ticks     = 8'd0;
		crossings      = 8'd0;
		missed_ticks   = 8'd0;
	endfunction

	function automatic void trip_fault(input logic [2:0] cause);
		pr_mode   = MODE_FAULT;
		pr_lock   = LOCK_LOST;
		pr_fault  = pr_fault | cause;
		pr_duty   = 7'd0;
		pr_period = 16'd0;
		pr_speed  = 16'd0;
	endfunction

	function automatic res_t sequencer_tick(input in_t t);
		res_t r;
		int   thr;
		thr = int'(t.throttle);
		if (t.clear_request) begin
			clear_sequencer();
		end
		if (t.start_request && pr_mode == MODE_IDLE) begin
			clear_sequencer();
			pr_mode = MODE_ALIGN;
			pr_lock = LOCK_SEEKING;
			pr_duty = clamp_pct(thr / 2, ALIGN_DUTY_LO, ALIGN_DUTY_HI);
		end
		if ((pr_mode == MODE_ALIGN || pr_mode == MODE_OPEN || pr_mode == MODE_CLOSED)
				&& t.phase_current >= oc_limit_ma) begin
			trip_fault(FAULT_OVERCURRENT);
		end else if (pr_mode == MODE_ALIGN) begin
			align_progress = count_up(align_progress);
			pr_duty = clamp_pct(thr / 2, ALIGN_DUTY_LO, ALIGN_DUTY_HI);
			pr_speed = 16'd0;
			if (align_progress >= align_len) begin
				pr_mode = MODE_OPEN;
				pr_period = START_PERIOD_US;
				pr_duty = ramp_duty(thr);
				ramp_ticks = 8'd0;
				crossings = 8'd0;
			end
		end else if (pr_mode == MODE_OPEN) begin
			ramp_ticks = count_up(ramp_ticks);
			pr_sector = sector_after(pr_sector);
			if (pr_period > MIN_PERIOD_US) begin
				pr_period = (pr_period >= MIN_PERIOD_US + PERIOD_STEP_US)
					? pr_period - PERIOD_STEP_US : MIN_PERIOD_US;
			end
			pr_duty = ramp_duty(thr);
			pr_speed = (t.measured_speed != 16'd0) ? t.measured_speed
				: product_over(pr_period);
			if (t.zero_crossing) begin
				crossings = count_up(crossings);
			end
			if (crossings >= lock_events && pr_speed >= lock_rpm) begin
				pr_mode = MODE_CLOSED;
				pr_lock = LOCK_LOCKED;
				pr_duty = clamp_pct(thr, LOCK_DUTY_LO, LOCK_DUTY_HI);
				missed_ticks = 8'd0;
				if (t.measured_speed != 16'd0) begin
					pr_period = product_over(t.measured_speed);
					pr_speed = t.measured_speed;
				end
			end else if (ramp_ticks > ol_timeout) begin
				trip_fault(FAULT_NO_LOCK);
			end
		end else if (pr_mode == MODE_CLOSED) begin
			pr_duty = clamp_pct(thr, CLOSED_DUTY_LO, CLOSED_DUTY_HI);
			if (t.zero_crossing) begin
				pr_sector = sector_after(pr_sector);
				missed_ticks = 8'd0;
				if (t.measured_speed != 16'd0) begin
					pr_period = product_over(t.measured_speed);
					pr_speed = t.measured_speed;
				end else begin
					pr_speed = product_over(pr_period);
				end
			end else begin
				missed_ticks = count_up(missed_ticks);
				pr_speed = product_over(pr_period);
				if (missed_ticks > stall_limit) begin
					trip_fault(FAULT_STALL);
				end
			end
		end
		r.mode           = pr_mode;
		r.sector         = pr_sector;
		r.lock_status    = pr_lock;
		r.duty           = pr_duty;
		r.period_us      = pr_period;
		r.speed_estimate = pr_speed;
		r.fault_mask     = pr_fault;
		return r;
	endfunction

	function automatic in_t make_tick(input int st, input int cl, input int thr,
			input int cur, input int zc, input int meas);
		in_t t;
		t.start_request  = 1'(st);
		t.clear_request  = 1'(cl);
		t.throttle       = 7'(thr);
		t.phase_current  = 16'(cur);
		t.zero_crossing  = 1'(zc);
		t.measured_speed = 16'(meas);
		return t;
	endfunction

	function automatic logic [15:0] below_limit();
		if (oc_limit_ma == 16'd0) begin
			return 16'd0;
		end
		return 16'($urandom_range(0, oc_limit_ma - 16'd1));
	endfunction

	function automatic logic [15:0] speed_sample();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 16'd0;
		end else if (r < 70) begin
			return 16'($urandom_range(1, 65535));
		end
		return 16'($urandom_range(300, 12000));
	endfunction

	function automatic in_t calm_tick(input bit zc);
		return make_tick(0, 0, int'($urandom_range(0, 100)), int'(below_limit()), int'(zc),
			int'(speed_sample()));
	endfunction

	// mostly plausible drive sequences, some raw noise
	function automatic in_t session_tick();
		in_t t;
		if ($urandom_range(0, 99) < 8) begin
			t = make_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 100),
				$urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 65535));
		end else begin
			t = calm_tick($urandom_range(0, 99) < zc_percent);
			if (pr_mode == MODE_IDLE) begin
				t.start_request = ($urandom_range(0, 3) != 0);
			end else begin
				t.start_request = ($urandom_range(0, 15) == 0);
			end
			if (pr_mode == MODE_FAULT) begin
				t.clear_request = ($urandom_range(0, 2) == 0);
			end else begin
				t.clear_request = ($urandom_range(0, 59) == 0);
			end
			if ($urandom_range(0, 39) == 0) begin
				t.phase_current = 16'($urandom_range(oc_limit_ma, 65535));
			end
		end
		return t;
	endfunction

	function automatic logic [31:0] pick_setting(input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] typ_lo, input logic [31:0] typ_hi);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return lo;
		end else if (r == 1) begin
			return hi;
		end
		return $urandom_range(typ_hi, typ_lo);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_OC_LIMIT:      oc_limit_ma = value[15:0];
			CFG_PRODUCT:       rpm_product = value;
			CFG_LOCK_MIN_RPM:  lock_rpm    = value[15:0];
			CFG_ALIGN_LEN:     align_len   = value[7:0];
			CFG_OL_TIMEOUT:    ol_timeout  = value[7:0];
			CFG_LOCK_EVENTS:   lock_events = value[7:0];
			CFG_STALL_TIMEOUT: stall_limit = value[7:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] oc, input logic [31:0] prod,
			input logic [15:0] rpm, input logic [7:0] al, input logic [7:0] olt,
			input logic [7:0] ev, input logic [7:0] st);
		write_reg(CFG_OC_LIMIT, {16'd0, oc});
		write_reg(CFG_PRODUCT, prod);
		write_reg(CFG_LOCK_MIN_RPM, {16'd0, rpm});
		write_reg(CFG_ALIGN_LEN, {24'd0, al});
		write_reg(CFG_OL_TIMEOUT, {24'd0, olt});
		write_reg(CFG_LOCK_EVENTS, {24'd0, ev});
		write_reg(CFG_STALL_TIMEOUT, {24'd0, st});
	endtask

	task automatic send_tick(input in_t t);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		start_request  <= t.start_request;
		clear_request  <= t.clear_request;
		throttle       <= t.throttle;
		phase_current  <= t.phase_current;
		zero_crossing  <= t.zero_crossing;
		measured_speed <= t.measured_speed;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted_status.push_back(sequencer_tick(t));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (predicted_status.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_idle_and_clear();
		send_tick(make_tick(0, 0, 0, 0, 0, 0));
		send_tick(make_tick(0, 0, 100, 65535, 1, 65535));
		// clear and start in one tick
		send_tick(make_tick(1, 1, 100, int'(RST_OC_LIMIT) - 1, 0, 0));
		send_tick(make_tick(0, 0, 0, int'(RST_OC_LIMIT), 0, 0));
		// start is ignored while faulted
		send_tick(make_tick(1, 0, 50, 0, 1, 0));
		send_tick(make_tick(0, 1, 0, 0, 0, 0));
		wait_idle();
	endtask

	task automatic test_lock_and_stall();
		apply_settings(RST_OC_LIMIT, RST_PRODUCT, RST_LOCK_MIN_RPM, 8'd1, 8'd3, 8'd2, 8'd2);
		write_reg(CFG_SPARE, 32'hFFFF_FFFF);
		send_tick(make_tick(1, 0, 0, 0, 0, 0));
		send_tick(make_tick(0, 0, 7, 100, 1, 0));
		send_tick(make_tick(0, 0, 100, 200, 1, 65535));
		send_tick(make_tick(0, 0, 23, 0, 1, 0));
		send_tick(make_tick(0, 0, 90, 0, 0, 0));
		send_tick(make_tick(0, 0, 90, 0, 0, 1));
		send_tick(make_tick(0, 0, 90, 0, 0, 0));
		send_tick(make_tick(0, 1, 0, 0, 0, 0));
		wait_idle();
	endtask

	task automatic test_lock_timeout();
		send_tick(make_tick(1, 0, 60, 0, 0, 0));
		repeat (4) send_tick(make_tick(0, 0, 60, 1000, 0, 0));
		send_tick(make_tick(1, 1, 100, 0, 0, 0));
		// overcurrent while ramping
		send_tick(make_tick(0, 0, 100, 65535, 1, 4000));
		send_tick(make_tick(0, 1, 0, 0, 0, 0));
		wait_idle();
	endtask

	// every timeout at its top value: counters saturate and no fault fires
	task automatic test_counter_saturation();
		apply_settings(16'hFFFF, RST_PRODUCT, 16'd0, 8'd255, 8'd255, 8'd255, 8'd255);
		send_tick(make_tick(1, 0, 40, 0, 0, 0));
		while (pr_mode == MODE_ALIGN) send_tick(calm_tick(1'b0));
		while (pr_mode == MODE_OPEN) send_tick(calm_tick(1'b1));
		repeat (270) send_tick(calm_tick(1'b0));
		send_tick(make_tick(0, 1, 0, 0, 0, 0));
		wait_idle();
	endtask

	task automatic randomize_settings(input int phase);
		if (phase == 0) begin
			apply_settings(RST_OC_LIMIT, RST_PRODUCT, RST_LOCK_MIN_RPM, RST_ALIGN_LEN,
				RST_OL_TIMEOUT, RST_LOCK_EVENTS, RST_STALL_TIMEOUT);
		end else if (phase == 1) begin
			apply_settings(16'd0, 32'd1, 16'd0, 8'd1, 8'd1, 8'd1, 8'd1);
		end else if (phase == 2) begin
			apply_settings(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'd1, 8'd255, 8'd255, 8'd255);
		end else begin
			apply_settings(
				16'(pick_setting(0, 65535, 1500, 20000)),
				pick_setting(1, 32'hFFFF_FFFF, 200000, 40000000),
				16'(pick_setting(0, 65535, 0, 4000)),
				8'($urandom_range(1, 6)),
				8'(pick_setting(1, 255, 5, 40)),
				8'(pick_setting(1, 255, 1, 6)),
				8'(pick_setting(1, 255, 1, 12)));
		end
	endtask

	task automatic test_random_sessions();
		int  phase;
		int  counted;
		in_t t;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			randomize_settings(phase);
			steady_flow = (phase % 3 == 2);
			counted = 0;
			while (counted < PHASE_TICKS) begin
				// new zero-crossing density for each start attempt
				if (pr_mode == MODE_IDLE || pr_mode == MODE_FAULT) begin
					case ($urandom_range(0, 4))
						0: zc_percent = 5;
						1: zc_percent = 30;
						2: zc_percent = 60;
						3: zc_percent = 90;
						default: zc_percent = 100;
					endcase
				end
				t = session_tick();
				if ((pr_mode != MODE_IDLE && pr_mode != MODE_FAULT) || t.start_request
						|| t.clear_request) begin
					counted++;
				end
				send_tick(t);
			end
			wait_idle();
		end
		steady_flow = 1'b0;
	endtask

	initial begin : result_check
		int   stall;
		res_t want;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (predicted_status.size() == 0) begin
				if (mismatches < MISMATCH_REPORTS) begin
					$display("unexpected result transfer: mode %0d sector %0d", mode, sector);
				end
				mismatches++;
			end else begin
				want = predicted_status.pop_front();
				if (mode !== want.mode || sector !== want.sector
						|| lock_status !== want.lock_status || duty !== want.duty
						|| period_us !== want.period_us
						|| speed_estimate !== want.speed_estimate
						|| fault_mask !== want.fault_mask) begin
					if (mismatches < MISMATCH_REPORTS) begin
						$display("mismatch exp mode %0d sec %0d lock %0d duty %0d per %0d spd %0d flt %0d",
							want.mode, want.sector, want.lock_status, want.duty,
							want.period_us, want.speed_estimate, want.fault_mask);
						$display("         got mode %0d sec %0d lock %0d duty %0d per %0d spd %0d flt %0d",
							mode, sector, lock_status, duty, period_us, speed_estimate,
							fault_mask);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		start_request  = 1'b0;
		clear_request  = 1'b0;
		throttle       = '0;
		phase_current  = '0;
		zero_crossing  = 1'b0;
		measured_speed = '0;
		steady_flow    = 1'b0;
		zc_percent     = 50;
		mismatches     = 0;
		oc_limit_ma    = RST_OC_LIMIT;
		rpm_product    = RST_PRODUCT;
		lock_rpm       = RST_LOCK_MIN_RPM;
		align_len      = RST_ALIGN_LEN;
		ol_timeout     = RST_OL_TIMEOUT;
		lock_events    = RST_LOCK_EVENTS;
		stall_limit    = RST_STALL_TIMEOUT;
		clear_sequencer();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_and_clear();
		test_lock_and_stall();
		test_lock_timeout();
		test_counter_saturation();
		test_random_sessions();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && predicted_status.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
